// File: hdl/hor_pkg.sv
`timescale 1ns / 1ps

package hor_pkg;

    localparam int MINUTE_W   = 11;
    localparam int HUM_W      = 10;
    localparam int TIME_W     = 32;
    localparam int SEC_W      = 16;
    localparam int INTERVAL_W = 26;   // 65535 * 1000 fits in 26 bits
    localparam int WCOUNT_W   = 3;
    localparam int WIN_W      = 23;
    localparam int WREG_W     = 46;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 46;
    localparam int REASON_W   = 3;

    localparam logic [MINUTE_W-1:0] MINUTES_PER_DAY = 11'd1440;
    localparam logic [9:0]          MS_PER_S        = 10'd1000;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_MANUAL = 2'd0;
    localparam mode_t MODE_TIMED  = 2'd1;
    localparam mode_t MODE_AUTO   = 2'd2;
    localparam mode_t MODE_RSVD   = 2'd3;

    typedef logic [REASON_W-1:0] reason_t;
    localparam reason_t REASON_NONE    = 3'd0;
    localparam reason_t REASON_STARTUP = 3'd1;
    localparam reason_t REASON_MANUAL  = 3'd2;
    localparam reason_t REASON_SCHED   = 3'd3;
    localparam reason_t REASON_HUM_LOW = 3'd4;
    localparam reason_t REASON_HUM_HI  = 3'd5;
    localparam reason_t REASON_SAFETY  = 3'd6;
    localparam reason_t REASON_EMERG   = 3'd7;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_MODE      = 3'd0;
    localparam cfg_idx_t CFG_MANUAL_ON = 3'd1;
    localparam cfg_idx_t CFG_HUM_MIN   = 3'd2;
    localparam cfg_idx_t CFG_HUM_MAX   = 3'd3;
    localparam cfg_idx_t CFG_INTERVAL  = 3'd4;
    localparam cfg_idx_t CFG_WCOUNT    = 3'd5;
    localparam cfg_idx_t CFG_WIN_LOW   = 3'd6;
    localparam cfg_idx_t CFG_WIN_HIGH  = 3'd7;

    typedef struct packed {
        logic [MINUTE_W-1:0] minute_of_day;
        logic [TIME_W-1:0]   now_ms;
        logic [HUM_W-1:0]    humidity;
        logic                humidity_valid;
        logic                critical_fault;
        logic                offline_fallback;
        logic                emergency_off;
    } item_t;

    typedef struct packed {
        mode_t                 mode;
        logic                  manual_on;
        logic [HUM_W-1:0]      humidity_min;
        logic [HUM_W-1:0]      humidity_max;
        logic [INTERVAL_W-1:0] interval_ms;
    } ctl_cfg_t;

    typedef struct packed {
        logic              relay;
        logic [TIME_W-1:0] last_switch;
        mode_t             prev_mode;
        logic              started;
    } ctl_state_t;

    typedef struct packed {
        logic    relay_on;
        logic    changed;
        reason_t change_reason;
    } result_t;

endpackage

// File: hdl/hor_sched.sv
`timescale 1ns / 1ps

module hor_sched #(
    parameter int NUM_WINDOWS = 4
) (
    input  logic [hor_pkg::MINUTE_W-1:0] minute,
    input  logic [hor_pkg::WCOUNT_W-1:0] window_count,
    input  logic [hor_pkg::WREG_W-1:0]   windows_low,
    input  logic [hor_pkg::WREG_W-1:0]   windows_high,
    output logic                         hit
);

    localparam logic [hor_pkg::WCOUNT_W-1:0] MAX_WIN = hor_pkg::WCOUNT_W'(NUM_WINDOWS);

    logic [2*hor_pkg::WREG_W-1:0]  win_all;
    logic [hor_pkg::WCOUNT_W-1:0]  n_used;

    assign win_all = {windows_high, windows_low};
    assign n_used  = (window_count > MAX_WIN) ? MAX_WIN : window_count;

    always_comb
    begin
        logic [hor_pkg::WIN_W-1:0]    w;
        logic [hor_pkg::MINUTE_W-1:0] w_start;
        logic [hor_pkg::MINUTE_W-1:0] w_end;
        logic                         in_win;
        hit = 1'b0;
        for (int i = 0; i < NUM_WINDOWS; i++)
        begin
            w       = win_all[i*hor_pkg::WIN_W +: hor_pkg::WIN_W];
            w_start = w[11:1];
            w_end   = w[22:12];
            if (w_start <= w_end)
                in_win = (minute >= w_start) && (minute < w_end);
            else
                in_win = (minute >= w_start) || (minute < w_end);
            // out-of-day start or end minute disables the window
            if (hor_pkg::WCOUNT_W'(i) < n_used && w[0] &&
                w_start < hor_pkg::MINUTES_PER_DAY && w_end < hor_pkg::MINUTES_PER_DAY &&
                in_win)
                hit = 1'b1;
        end
    end

endmodule

// File: hdl/hor_decide.sv
`timescale 1ns / 1ps

module hor_decide (
    input  hor_pkg::item_t      item,
    input  hor_pkg::ctl_cfg_t   cfg,
    input  hor_pkg::ctl_state_t cur,
    input  logic                sched_hit,
    output hor_pkg::ctl_state_t nxt,
    output hor_pkg::result_t    res
);

    always_comb
    begin
        hor_pkg::mode_t                 m;
        hor_pkg::mode_t                 eff;
        logic                           mode_chg;
        logic [hor_pkg::TIME_W-1:0]     iv;
        logic [hor_pkg::TIME_W-1:0]     last_base;
        logic [hor_pkg::TIME_W-1:0]     elapsed;
        logic                           want;
        logic                           may;
        logic                           hum_ok;

        nxt     = cur;
        res.changed       = 1'b0;
        res.change_reason = hor_pkg::REASON_NONE;

        m         = (cfg.mode == hor_pkg::MODE_RSVD) ? hor_pkg::MODE_AUTO : cfg.mode;
        eff       = item.offline_fallback ? hor_pkg::MODE_TIMED : m;
        mode_chg  = eff != cur.prev_mode;
        iv        = {{(hor_pkg::TIME_W-hor_pkg::INTERVAL_W){1'b0}}, cfg.interval_ms};
        hum_ok    = item.humidity_valid && !item.critical_fault;
        // on a mode change the hold-off is backdated so a switch may happen now
        if (mode_chg)
            last_base = (item.now_ms > iv) ? item.now_ms - iv : '0;
        else
            last_base = cur.last_switch;
        elapsed   = item.now_ms - last_base;
        want      = cur.relay;
        may       = 1'b0;

        if (item.emergency_off)
        begin
            nxt.relay         = 1'b0;
            nxt.last_switch   = item.now_ms;
            res.changed       = 1'b1;
            res.change_reason = hor_pkg::REASON_EMERG;
        end
        else if (!cur.started)
        begin
            case (m)
                hor_pkg::MODE_MANUAL: want = cfg.manual_on;
                hor_pkg::MODE_TIMED:  want = sched_hit;
                default:              want = hum_ok && (item.humidity < cfg.humidity_min);
            endcase
            nxt.relay         = want;
            nxt.last_switch   = item.now_ms;
            nxt.prev_mode     = m;
            nxt.started       = 1'b1;
            res.changed       = 1'b1;
            res.change_reason = hor_pkg::REASON_STARTUP;
        end
        else
        begin
            nxt.last_switch = last_base;
            nxt.prev_mode   = eff;
            if (item.critical_fault && eff == hor_pkg::MODE_AUTO)
            begin
                if (cur.relay)
                begin
                    nxt.relay         = 1'b0;
                    nxt.last_switch   = item.now_ms;
                    res.changed       = 1'b1;
                    res.change_reason = hor_pkg::REASON_SAFETY;
                end
            end
            else
            begin
                case (eff)
                    hor_pkg::MODE_MANUAL: want = cfg.manual_on;
                    hor_pkg::MODE_TIMED:  want = sched_hit;
                    default:
                    begin
                        if (item.humidity_valid)
                        begin
                            if (item.humidity < cfg.humidity_min)
                                want = 1'b1;
                            else if (item.humidity >= cfg.humidity_max)
                                want = 1'b0;
                        end
                    end
                endcase
                may = mode_chg || eff != hor_pkg::MODE_AUTO || elapsed >= iv;
                if (want != cur.relay && may)
                begin
                    nxt.relay       = want;
                    nxt.last_switch = item.now_ms;
                    res.changed     = 1'b1;
                    case (eff)
                        hor_pkg::MODE_MANUAL: res.change_reason = hor_pkg::REASON_MANUAL;
                        hor_pkg::MODE_TIMED:  res.change_reason = hor_pkg::REASON_SCHED;
                        default:
                            res.change_reason = want ? hor_pkg::REASON_HUM_LOW
                                                     : hor_pkg::REASON_HUM_HI;
                    endcase
                end
            end
        end
        res.relay_on = nxt.relay;
    end

endmodule

// File: hdl/humidity_on_off_regulator.sv
`timescale 1ns / 1ps

// On/off regulator for one humidifier relay zone. Each accepted tick gives
// exactly one result (relay drive, changed flag, reason). A tick is captured in
// an input register, evaluated combinationally against the zone state, and the
// result lands in an output register, so the block takes one tick per cycle
// while results are taken; the input register also holds one tick while a
// result waits to be taken. Configuration writes take effect on the next edge
// and are meant to happen while no tick is in flight. NUM_WINDOWS (1..4) sets
// how many schedule windows are evaluated; window_count is clamped to it.
module humidity_on_off_regulator #(
    parameter int NUM_WINDOWS = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [hor_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hor_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hor_pkg::MINUTE_W-1:0]   minute_of_day,
    input  logic [hor_pkg::TIME_W-1:0]     now_ms,
    input  logic [hor_pkg::HUM_W-1:0]      humidity,
    input  logic                           humidity_valid,
    input  logic                           critical_fault,
    input  logic                           offline_fallback,
    input  logic                           emergency_off,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           relay_on,
    output logic                           changed,
    output logic [hor_pkg::REASON_W-1:0]   change_reason
);

    hor_pkg::ctl_cfg_t             cfg_reg;
    logic [hor_pkg::WCOUNT_W-1:0]  wcount_reg;
    logic [hor_pkg::WREG_W-1:0]    win_low_reg;
    logic [hor_pkg::WREG_W-1:0]    win_high_reg;

    hor_pkg::item_t                item_reg;
    logic                          item_valid_reg;
    hor_pkg::ctl_state_t           state_reg;
    hor_pkg::ctl_state_t           state_next;
    hor_pkg::result_t              res_next;
    hor_pkg::result_t              res_reg;
    logic                          out_valid_reg;
    logic                          sched_hit;
    logic                          advance;
    logic [hor_pkg::INTERVAL_W-1:0] interval_next;

    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign relay_on      = res_reg.relay_on;
    assign changed       = res_reg.changed;
    assign change_reason = res_reg.change_reason;

    // seconds to milliseconds, done once at write time
    assign interval_next = hor_pkg::INTERVAL_W'(cfg_data[hor_pkg::SEC_W-1:0])
                         * hor_pkg::INTERVAL_W'(hor_pkg::MS_PER_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= hor_pkg::MODE_MANUAL;
            cfg_reg.manual_on    <= 1'b0;
            cfg_reg.humidity_min <= '0;
            cfg_reg.humidity_max <= 10'd1000;
            cfg_reg.interval_ms  <= '0;
            wcount_reg           <= '0;
            win_low_reg          <= '0;
            win_high_reg         <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                hor_pkg::CFG_MODE:      cfg_reg.mode         <= cfg_data[1:0];
                hor_pkg::CFG_MANUAL_ON: cfg_reg.manual_on    <= cfg_data[0];
                hor_pkg::CFG_HUM_MIN:   cfg_reg.humidity_min <= cfg_data[hor_pkg::HUM_W-1:0];
                hor_pkg::CFG_HUM_MAX:   cfg_reg.humidity_max <= cfg_data[hor_pkg::HUM_W-1:0];
                hor_pkg::CFG_INTERVAL:  cfg_reg.interval_ms  <= interval_next;
                hor_pkg::CFG_WCOUNT:    wcount_reg   <= cfg_data[hor_pkg::WCOUNT_W-1:0];
                hor_pkg::CFG_WIN_LOW:   win_low_reg  <= cfg_data[hor_pkg::WREG_W-1:0];
                hor_pkg::CFG_WIN_HIGH:  win_high_reg <= cfg_data[hor_pkg::WREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.minute_of_day    <= minute_of_day;
            item_reg.now_ms           <= now_ms;
            item_reg.humidity         <= humidity;
            item_reg.humidity_valid   <= humidity_valid;
            item_reg.critical_fault   <= critical_fault;
            item_reg.offline_fallback <= offline_fallback;
            item_reg.emergency_off    <= emergency_off;
        end
    end

    hor_sched #(
        .NUM_WINDOWS (NUM_WINDOWS)
    ) u_sched (
        .minute       (item_reg.minute_of_day),
        .window_count (wcount_reg),
        .windows_low  (win_low_reg),
        .windows_high (win_high_reg),
        .hit          (sched_hit)
    );

    hor_decide u_decide (
        .item      (item_reg),
        .cfg       (cfg_reg),
        .cur       (state_reg),
        .sched_hit (sched_hit),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

endmodule

// File: hdl/hor_checker.sv
`timescale 1ns / 1ps

module hor_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         relay_on,
    input logic                         changed,
    input logic [hor_pkg::REASON_W-1:0] change_reason
);

    // a result that is not taken stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(relay_on) && $stable(changed)
                                   && $stable(change_reason))
        else $error("stalled result changed");

    a_reason_iff_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (changed == (change_reason != hor_pkg::REASON_NONE)))
        else $error("changed flag and reason disagree");

    a_off_reasons: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (change_reason == hor_pkg::REASON_HUM_HI ||
                      change_reason == hor_pkg::REASON_SAFETY ||
                      change_reason == hor_pkg::REASON_EMERG) |-> !relay_on)
        else $error("turn-off reason with relay on");

    a_on_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && change_reason == hor_pkg::REASON_HUM_LOW |-> relay_on)
        else $error("humidity-low reason with relay off");

endmodule

bind humidity_on_off_regulator hor_checker u_hor_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .relay_on      (relay_on),
    .changed       (changed),
    .change_reason (change_reason)
);
